>>> hdl/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg: shared types for the priority ready queue
// Request and result beat layouts, request modes and sequencer states.
// ----------------------------------------------------------------------------
package prq_pkg;

  // request modes, the unused code is refused by the core
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_POP    = 2'd2
  } prq_mode_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_LINK,
    ST_UNLINK,
    ST_DONE
  } prq_state_e;

  // request beat
  typedef struct packed {
    prq_mode_e  mode;
    logic [4:0] job_id;
    logic [4:0] job_priority;
  } prq_in_t;

  // result beat
  typedef struct packed {
    logic [4:0] result_job;
    logic       empty_flag;
    logic       error_flag;
  } prq_out_t;

endpackage

>>> hdl/priority_ready_queue_core.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_core: priority ordered ready queue of job ids
// Doubly linked list of jobs in three small memories, walked by a sequencer.
// ----------------------------------------------------------------------------
// One request beat is taken at a time. On insert, the sequencer passes
// every queued job with a priority number not above the new one (at most
// JOB_COUNT - 1 of them), walking the list one entry per cycle through the
// registered read port of the link and priority memories, with a single
// compare against the stored priority, then links the job in between its
// neighbours. Remove and pop go through the unlink state, refused requests
// and pop on an empty queue go to the done state. The next request is taken
// as soon as the result sits in the output register, even if not yet taken.
// Equal priorities keep arrival order; insert of a queued job, removal of an
// absent job and the unused mode code give a result with the error flag set.
module priority_ready_queue_core import prq_pkg::*; #(
  parameter int unsigned JOB_COUNT       = 32,
  parameter int unsigned PRIORITY_LEVELS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  prq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output prq_out_t out_data_o
);

  localparam int unsigned IdxW  = (JOB_COUNT > 1) ? $clog2(JOB_COUNT) : 1;
  localparam int unsigned LinkW = $clog2(JOB_COUNT + 1);
  localparam int unsigned PrioW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam logic [LinkW-1:0] NullLink = LinkW'(JOB_COUNT);
  localparam logic [PrioW-1:0] PrioMax  = PrioW'(PRIORITY_LEVELS - 1);

  prq_state_e           state_q, state_d;
  logic [IdxW-1:0]      job_q, job_d;
  logic [PrioW-1:0]     prio_q, prio_d;
  logic [LinkW-1:0]     cur_q, cur_d;
  logic [LinkW-1:0]     pv_q, pv_d;
  logic [LinkW-1:0]     head_q, head_d;
  logic [LinkW-1:0]     tail_q, tail_d;
  logic [JOB_COUNT-1:0] mark_q, mark_d;
  prq_out_t             res_q, res_d;
  prq_out_t             out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  // memory ports
  logic [IdxW-1:0]  rd_addr;
  logic             next_we, prev_we, prio_we;
  logic [IdxW-1:0]  next_waddr, prev_waddr;
  logic [LinkW-1:0] next_wdata, prev_wdata;
  logic [LinkW-1:0] next_rdata, prev_rdata;
  logic [PrioW-1:0] prio_rdata;

  // request decode
  logic             in_job_ok;
  logic [IdxW-1:0]  in_job_idx;
  logic [PrioW-1:0] in_prio_sat;
  logic             head_is_job;
  logic [LinkW-1:0] job_link;
  logic [LinkW-1:0] walk_pv;

  assign in_job_ok   = 32'(in_data_i.job_id) < JOB_COUNT;
  assign in_job_idx  = IdxW'(in_data_i.job_id);
  assign in_prio_sat = (32'(in_data_i.job_priority) >= PRIORITY_LEVELS)
                       ? PrioMax
                       : PrioW'(in_data_i.job_priority);
  assign head_is_job = head_q != NullLink;
  assign job_link    = LinkW'(job_q);
  assign walk_pv     = (cur_q == NullLink) ? tail_q : prev_rdata;

  // link and priority stores
  prq_ram #(.WIDTH(LinkW), .DEPTH(JOB_COUNT)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (rd_addr),
    .rdata_o (next_rdata)
  );

  prq_ram #(.WIDTH(LinkW), .DEPTH(JOB_COUNT)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (rd_addr),
    .rdata_o (prev_rdata)
  );

  prq_ram #(.WIDTH(PrioW), .DEPTH(JOB_COUNT)) u_prio_ram (
    .clk_i   (clk_i),
    .we_i    (prio_we),
    .waddr_i (job_q),
    .wdata_i (prio_q),
    .raddr_i (rd_addr),
    .rdata_o (prio_rdata)
  );

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= NullLink;
      tail_q      <= NullLink;
      mark_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      mark_q      <= mark_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    prio_q <= prio_d;
    cur_q  <= cur_d;
    pv_q   <= pv_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // next state, memory control and result
  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    prio_d      = prio_q;
    cur_d       = cur_q;
    pv_d        = pv_q;
    head_d      = head_q;
    tail_d      = tail_q;
    mark_d      = mark_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rd_addr     = head_q[IdxW-1:0];
    next_we     = 1'b0;
    prev_we     = 1'b0;
    prio_we     = 1'b0;
    next_waddr  = job_q;
    prev_waddr  = job_q;
    next_wdata  = cur_q;
    prev_wdata  = walk_pv;
    in_ready_o  = state_q == ST_IDLE;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          job_d  = in_job_idx;
          prio_d = in_prio_sat;
          res_d  = '{result_job: in_data_i.job_id, empty_flag: 1'b0, error_flag: 1'b0};
          case (in_data_i.mode)
            MODE_INSERT: begin
              if (!in_job_ok || mark_q[in_job_idx]) begin
                res_d.error_flag = 1'b1;
                state_d          = ST_DONE;
              end else begin
                cur_d   = head_q;
                state_d = ST_WALK;
              end
            end
            MODE_REMOVE: begin
              if (!in_job_ok || !mark_q[in_job_idx]) begin
                res_d.error_flag = 1'b1;
                state_d          = ST_DONE;
              end else begin
                rd_addr = in_job_idx;
                state_d = ST_UNLINK;
              end
            end
            MODE_POP: begin
              if (!head_is_job) begin
                res_d   = '{result_job: 5'd0, empty_flag: 1'b1, error_flag: 1'b0};
                state_d = ST_DONE;
              end else begin
                res_d.result_job = 5'(head_q);
                job_d            = head_q[IdxW-1:0];
                state_d          = ST_UNLINK;
              end
            end
            default: begin
              res_d   = '{result_job: 5'd0, empty_flag: 1'b0, error_flag: 1'b1};
              state_d = ST_DONE;
            end
          endcase
        end
      end

      // one list entry per cycle, read data belongs to cur_q
      ST_WALK: begin
        if (cur_q != NullLink && !(prio_rdata > prio_q)) begin
          cur_d   = next_rdata;
          rd_addr = next_rdata[IdxW-1:0];
        end else begin
          next_we = 1'b1;
          prev_we = 1'b1;
          prio_we = 1'b1;
          pv_d    = walk_pv;
          state_d = ST_LINK;
        end
      end

      // hook the new job in between pv_q and cur_q
      ST_LINK: begin
        if (cur_q != NullLink) begin
          prev_we    = 1'b1;
          prev_waddr = cur_q[IdxW-1:0];
          prev_wdata = job_link;
        end else begin
          tail_d = job_link;
        end
        if (pv_q != NullLink) begin
          next_we    = 1'b1;
          next_waddr = pv_q[IdxW-1:0];
          next_wdata = job_link;
        end else begin
          head_d = job_link;
        end
        mark_d[job_q] = 1'b1;
        state_d       = ST_DONE;
      end

      // read data holds the links of job_q
      ST_UNLINK: begin
        if (next_rdata != NullLink) begin
          prev_we    = 1'b1;
          prev_waddr = next_rdata[IdxW-1:0];
          prev_wdata = prev_rdata;
        end else begin
          tail_d = prev_rdata;
        end
        if (prev_rdata != NullLink) begin
          next_we    = 1'b1;
          next_waddr = prev_rdata[IdxW-1:0];
          next_wdata = next_rdata;
        end else begin
          head_d = next_rdata;
        end
        mark_d[job_q] = 1'b0;
        state_d       = ST_DONE;
      end

      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // head and tail are null together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == NullLink) == (tail_q == NullLink))
    else $error("head and tail disagree on empty queue");

  // queue marks agree with the list being empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mark_q == '0) == (head_q == NullLink))
    else $error("queued marks disagree with list head");

  // an accepted request starts the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != ST_IDLE)
    else $error("accepted request left sequencer idle");

  // a finished result reaches the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && (!out_valid_q || out_ready_i) |=> out_valid_q && state_q == ST_IDLE)
    else $error("result not handed to output register");

endmodule

>>> hdl/prq_ram.sv
// ----------------------------------------------------------------------------
// prq_ram: generic single write, single read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module prq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
